>>> rtl/qrs_pkg.sv
// qrs_pkg: shared constants, types and helper functions of the QRS peak detector.
// Used by qrs_ctrl, qrs_dp and qrs_peak_detector; depends on nothing.

package qrs_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int IDX_W        = 32;
  localparam int RR_W         = 16;
  localparam int PEAK_DEPTH   = 32;                 // power of two, circular peak store
  localparam int PEAK_AW      = $clog2(PEAK_DEPTH);
  localparam int FILL_W       = $clog2(PEAK_DEPTH + 1);
  localparam int PEAK_W       = SAMPLE_WIDTH + IDX_W;
  localparam int RR_DEPTH     = 8;
  localparam int RR_IW        = (RR_DEPTH > 1) ? $clog2(RR_DEPTH) : 1;
  localparam int CNT_W        = $clog2(RR_DEPTH + 1);
  localparam int SUM_W        = RR_W + $clog2(RR_DEPTH + 1);
  localparam int DIV_CW       = $clog2(SUM_W);
  localparam int REM_W        = CNT_W + 1;
  localparam int LVL_FRAC     = 3;
  localparam int LVL_W        = SAMPLE_WIDTH + LVL_FRAC;
  localparam int ACC_W        = LVL_W + 3;
  localparam int COEF_W       = 11;
  localparam int COEF_SHIFT   = 10;
  localparam int PROD_W       = RR_W + COEF_W;
  localparam int MISS_W       = 4;
  localparam logic [MISS_W-1:0] MISS_MAX = '1;

  localparam logic [COEF_W-1:0] COEF_LOW  = 11'd942;
  localparam logic [COEF_W-1:0] COEF_HIGH = 11'd1188;
  localparam logic [COEF_W-1:0] COEF_MISS = 11'd1700;

  // Configuration port
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 16;
  localparam logic [CFG_AW-1:0] CFG_LOW_LEVEL  = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_MISS_LIMIT = 1'd1;
  localparam logic [SAMPLE_WIDTH-1:0] LOW_LEVEL_RST  = 16'd2000;
  localparam logic [MISS_W-1:0]       MISS_LIMIT_RST = 4'd5;

  // Output packing: value, index, rr, by_searchback, low warning, miss warning
  localparam int OUT_FIELDS_W = SAMPLE_WIDTH + IDX_W + RR_W + 3;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // RR limit slots
  typedef enum logic [1:0] {
    LIM_LOW  = 2'd0,
    LIM_HIGH = 2'd1,
    LIM_MISS = 2'd2
  } lim_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PEAK,
    ST_NOISE,
    ST_CAND,
    ST_INIT_LIM,
    ST_DECIDE,
    ST_SB_RD,
    ST_SB_CHK,
    ST_SB_HIT,
    ST_MEAN,
    ST_DIV,
    ST_LIM,
    ST_THR,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_PEAK,
    OP_NOISE,
    OP_LIM_LOAD_RR,
    OP_LIM_STEP,
    OP_DECIDE,
    OP_SB_READ,
    OP_SB_CHECK,
    OP_SB_HIT,
    OP_MEAN_STEP,
    OP_DIV_STEP,
    OP_THR,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic is_peak;
    logic above_thr1;
    logic started;
    logic accept;
    logic sb_need;
    logic sb_empty;
    logic sb_qual;
    logic sb_end;
    logic mean_last;
    logic div_last;
    logic lim_last;
    logic pending;
    logic out_free;
  } dp_stat_t;

  function automatic logic [COEF_W-1:0] lim_coef(input logic [1:0] sel);
    logic [COEF_W-1:0] c;
    case (sel)
      LIM_LOW:  c = COEF_LOW;
      LIM_HIGH: c = COEF_HIGH;
      default:  c = COEF_MISS;
    endcase
    return c;
  endfunction

  // Saturate an index difference to the RR width.
  function automatic logic [RR_W-1:0] sat_rr(input logic [IDX_W-1:0] d);
    return (|d[IDX_W-1:RR_W]) ? {RR_W{1'b1}} : d[RR_W-1:0];
  endfunction

endpackage

>>> rtl/qrs_peak_detector.sv
// qrs_peak_detector: top level of the QRS peak detector.
// Depends on qrs_pkg, qrs_ctrl, qrs_dp (and through it qrs_ram).
//
// Usage:
//   in_*  : one filtered, integrated ECG sample per transaction (16 bits, unsigned).
//   out_* : zero or one result per sample. A result appears when an R-peak is found
//           (directly or by searchback) or when the miss counter reaches its limit.
//   cfg_* : write-only registers: index 0 low value level, index 1 miss run limit.
//           Write them only while the block is idle.
// Timing: one sample at a time. A sample that is not a peak ends after the peak test, a
//   noise peak also updates the noise level and thresholds, an accepted beat runs 8 ring
//   steps, 20 divider steps and 3 limit multiplies, and a searchback scans the 32-entry
//   store with one RAM read per scanned peak. The first candidate also computes its
//   initial limits.
// Reset: all levels, thresholds, limits, rings and counters clear; the peak store
//   is tracked by a fill count and needs no clearing pass.
// Stall: a result waits in the output register; the next sample is still accepted
//   and only a later result waits for the register to drain.

module qrs_peak_detector (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [qrs_pkg::SAMPLE_WIDTH-1:0]   in_tdata,   // [15:0] sample
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] rpeak_value, [47:16] rpeak_index, [63:48] rr_length, [64] by_searchback,
  // [65] low_value_warning, [66] miss_run_warning, [71:67] zero
  output logic [qrs_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tuser,  // [0] rpeak_valid
  input  logic                               cfg_we,
  input  logic [qrs_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [qrs_pkg::CFG_DW-1:0]         cfg_wdata
);
  import qrs_pkg::*;

  op_t      op;
  dp_stat_t stat;

  // Sequencer: one datapath operation per cycle
  qrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .op        (op)
  );

  // Datapath with peak store and output register
  qrs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .stat       (stat),
    .sample     (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Hold off the next sample while one is in work
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted again right after a transaction");

  // A result without an R-peak only reports a miss run
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser || out_tdata[66]))
    else $error("result with neither R-peak nor miss warning");

  a_warning_only_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[65:0] == '0))
    else $error("warning-only result carries peak fields");

  a_searchback_is_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[64]) |-> out_tuser)
    else $error("searchback flag without R-peak");

endmodule

>>> rtl/qrs_ram.sv
// qrs_ram: generic single-port RAM with registered read data.
// Stand-alone; holds the peak store of the detector.

module qrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/qrs_ctrl.sv
// qrs_ctrl: sequencing state machine of the QRS peak detector.
// Depends on qrs_pkg; drives one datapath operation per cycle into qrs_dp.

module qrs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  qrs_pkg::dp_stat_t stat,
  output qrs_pkg::op_t      op
);
  import qrs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op        = OP_CAPTURE;
          state_nxt = ST_PEAK;
        end
      end
      ST_PEAK: begin
        op = OP_PEAK;
        if (!stat.is_peak) state_nxt = ST_IDLE;
        else if (stat.above_thr1) state_nxt = ST_CAND;
        else state_nxt = ST_NOISE;
      end
      ST_NOISE: begin
        op        = OP_NOISE;
        state_nxt = ST_THR;
      end
      ST_CAND: begin
        if (stat.started) begin
          state_nxt = ST_DECIDE;
        end else begin
          op        = OP_LIM_LOAD_RR;
          state_nxt = ST_INIT_LIM;
        end
      end
      ST_INIT_LIM: begin
        op = OP_LIM_STEP;
        if (stat.lim_last) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        op = OP_DECIDE;
        if (stat.accept) state_nxt = ST_MEAN;
        else if (stat.sb_need && !stat.sb_empty) state_nxt = ST_SB_RD;
        else state_nxt = ST_EMIT;
      end
      ST_SB_RD: begin
        op        = OP_SB_READ;
        state_nxt = ST_SB_CHK;
      end
      ST_SB_CHK: begin
        op = OP_SB_CHECK;
        if (stat.sb_qual) state_nxt = ST_SB_HIT;
        else if (stat.sb_end) state_nxt = ST_EMIT;
        else state_nxt = ST_SB_RD;
      end
      ST_SB_HIT: begin
        op        = OP_SB_HIT;
        state_nxt = ST_MEAN;
      end
      ST_MEAN: begin
        op = OP_MEAN_STEP;
        if (stat.mean_last) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        op = OP_DIV_STEP;
        if (stat.div_last) state_nxt = ST_LIM;
      end
      ST_LIM: begin
        op = OP_LIM_STEP;
        if (stat.lim_last) state_nxt = ST_THR;
      end
      ST_THR: begin
        op        = OP_THR;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.pending) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          op        = OP_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/qrs_dp.sv
// qrs_dp: datapath of the QRS peak detector: sample history, peak store, RR rings,
// levels, thresholds, RR limits, mean divider and output register.
// Depends on qrs_pkg and qrs_ram; commanded by qrs_ctrl.

module qrs_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  qrs_pkg::op_t                      op,
  output qrs_pkg::dp_stat_t                 stat,
  input  logic [qrs_pkg::SAMPLE_WIDTH-1:0]  sample,
  input  logic                              cfg_we,
  input  logic [qrs_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [qrs_pkg::CFG_DW-1:0]        cfg_wdata,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [qrs_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tuser
);
  import qrs_pkg::*;

  // Persistent state
  logic [SAMPLE_WIDTH-1:0] prev0_r, prev1_r;
  logic [IDX_W-1:0]        count_r, last_r;
  logic [RR_W-1:0]         ok_ring_r  [RR_DEPTH];
  logic [RR_W-1:0]         all_ring_r [RR_DEPTH];
  logic [LVL_W-1:0]        sig_r, noise_r;
  logic [SAMPLE_WIDTH-1:0] thr1_r, thr2_r;
  logic [RR_W-1:0]         lim_r [3];
  logic                    started_r;
  logic [MISS_W-1:0]       miss_r;
  logic [SAMPLE_WIDTH-1:0] low_level_r;
  logic [MISS_W-1:0]       miss_limit_r;
  logic [PEAK_AW-1:0]      wptr_r;
  logic [FILL_W-1:0]       fill_r;

  // Per-item working registers
  logic [SAMPLE_WIDTH-1:0] cand_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    is_peak_r;
  logic [RR_W-1:0]         rr_r;
  logic [PEAK_AW-1:0]      k_r;
  logic                    sel_ok_r;
  logic [RR_IW-1:0]        j_r;
  logic [SUM_W-1:0]        sum_r, q_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [REM_W-1:0]        rem_r;
  logic [DIV_CW-1:0]       dcnt_r;
  logic [RR_W-1:0]         base_r;
  logic [1:0]              lcnt_r;

  // Pending result
  logic                    res_valid_r, res_sb_r, warn_r;
  logic [SAMPLE_WIDTH-1:0] res_val_r;
  logic [IDX_W-1:0]        res_idx_r;
  logic [RR_W-1:0]         res_rr_r;

  // Output register
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic                    out_user_r;

  // Peak store
  logic                    ram_we;
  logic [PEAK_AW-1:0]      ram_addr;
  logic [PEAK_W-1:0]       ram_rdata;
  logic [SAMPLE_WIDTH-1:0] sb_val;
  logic [IDX_W-1:0]        sb_idx;

  assign ram_we   = (op == OP_PEAK) && is_peak_r;
  assign ram_addr = (op == OP_PEAK) ? wptr_r : (wptr_r - PEAK_AW'(1) - k_r);
  assign sb_val   = ram_rdata[SAMPLE_WIDTH-1:0];
  assign sb_idx   = ram_rdata[PEAK_W-1:SAMPLE_WIDTH];

  qrs_ram #(.WIDTH(PEAK_W), .DEPTH(PEAK_DEPTH)) u_peak_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({idx_r, cand_r}),
    .rdata (ram_rdata)
  );

  // Combinational helpers
  logic [RR_W-1:0]   rr_calc, rr_sb;
  logic [ACC_W-1:0]  sig_acc, sig_sb, noise_acc;
  logic [LVL_W+1:0]  thr_sum;
  logic [RR_W-1:0]   melem;
  logic              mnz;
  logic [SUM_W-1:0]  sum_add;
  logic [CNT_W-1:0]  cnt_add;
  logic [REM_W-1:0]  rem_sh, rem_nxt;
  logic              div_ge;
  logic [SUM_W-1:0]  q_nxt;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-COEF_SHIFT-1:0] prod_sh;
  logic [RR_W-1:0]   lim_val;
  logic              miss_hit;
  logic [MISS_W-1:0] miss_inc;

  assign rr_calc   = (idx_r >= last_r) ? sat_rr(idx_r - last_r) : '0;
  assign rr_sb     = sat_rr(sb_idx - last_r);
  assign sig_acc   = (ACC_W'({cand_r, 3'b000}) + ACC_W'(sig_r) * ACC_W'(7)) >> 3;
  assign sig_sb    = (ACC_W'({sb_val, 3'b000}) + ACC_W'(sig_r) * ACC_W'(3)) >> 2;
  assign noise_acc = (ACC_W'({cand_r, 3'b000}) + ACC_W'(noise_r) * ACC_W'(7)) >> 3;
  assign thr_sum   = (LVL_W+2)'(noise_r) * (LVL_W+2)'(3) + (LVL_W+2)'(sig_r);

  assign melem   = sel_ok_r ? ok_ring_r[j_r] : all_ring_r[j_r];
  assign mnz     = (melem != '0);
  assign sum_add = sum_r + (mnz ? SUM_W'(melem) : '0);
  assign cnt_add = cnt_r + CNT_W'(mnz);

  assign rem_sh  = {rem_r[REM_W-2:0], q_r[SUM_W-1]};
  assign div_ge  = (rem_sh >= REM_W'(cnt_r));
  assign rem_nxt = div_ge ? (rem_sh - REM_W'(cnt_r)) : rem_sh;
  assign q_nxt   = {q_r[SUM_W-2:0], div_ge};

  assign prod    = PROD_W'(base_r) * PROD_W'(lim_coef(lcnt_r));
  assign prod_sh = prod[PROD_W-1:COEF_SHIFT];
  assign lim_val = (|prod_sh[PROD_W-COEF_SHIFT-1:RR_W]) ? {RR_W{1'b1}} : prod_sh[RR_W-1:0];

  assign miss_hit = ((rr_r < lim_r[LIM_LOW]) || (rr_r > lim_r[LIM_HIGH])) && (miss_r < MISS_MAX);
  assign miss_inc = miss_r + MISS_W'(1);

  // Status to the controller
  always_comb begin
    stat.is_peak    = is_peak_r;
    stat.above_thr1 = cand_r > thr1_r;
    stat.started    = started_r;
    stat.accept     = (rr_r > lim_r[LIM_LOW]) && (rr_r < lim_r[LIM_HIGH]);
    stat.sb_need    = rr_r > lim_r[LIM_MISS];
    stat.sb_empty   = fill_r < FILL_W'(2);
    stat.sb_qual    = (sb_val > thr2_r) && (sb_idx > last_r);
    stat.sb_end     = (FILL_W'(k_r) + FILL_W'(1)) >= fill_r;
    stat.mean_last  = (j_r == RR_IW'(RR_DEPTH - 1));
    stat.div_last   = (dcnt_r == DIV_CW'(SUM_W - 1));
    stat.lim_last   = (lcnt_r == LIM_MISS);
    stat.pending    = res_valid_r || warn_r;
    stat.out_free   = !out_valid_r || out_tready;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_level_r  <= LOW_LEVEL_RST;
      miss_limit_r <= MISS_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LOW_LEVEL:  low_level_r  <= cfg_wdata[SAMPLE_WIDTH-1:0];
        CFG_MISS_LIMIT: miss_limit_r <= cfg_wdata[MISS_W-1:0];
        default: ;
      endcase
    end
  end

  // Detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev0_r   <= '0;
      prev1_r   <= '0;
      count_r   <= '0;
      last_r    <= '0;
      sig_r     <= '0;
      noise_r   <= '0;
      thr1_r    <= '0;
      thr2_r    <= '0;
      started_r <= 1'b0;
      miss_r    <= '0;
      wptr_r    <= '0;
      fill_r    <= '0;
      for (int i = 0; i < RR_DEPTH; i++) begin
        ok_ring_r[i]  <= '0;
        all_ring_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) lim_r[i] <= '0;
      res_valid_r <= 1'b0;
      warn_r      <= 1'b0;
    end else begin
      case (op)
        OP_CAPTURE: begin
          cand_r      <= prev0_r;
          idx_r       <= count_r;
          is_peak_r   <= (prev1_r < prev0_r) && (prev0_r > sample);
          prev1_r     <= prev0_r;
          prev0_r     <= sample;
          if (count_r != '1) count_r <= count_r + IDX_W'(1);
          res_valid_r <= 1'b0;
          res_sb_r    <= 1'b0;
          warn_r      <= 1'b0;
          res_val_r   <= '0;
          res_idx_r   <= '0;
          res_rr_r    <= '0;
        end
        OP_PEAK: begin
          rr_r <= rr_calc;
          if (is_peak_r) begin
            wptr_r <= wptr_r + PEAK_AW'(1);
            if (fill_r != FILL_W'(PEAK_DEPTH)) fill_r <= fill_r + FILL_W'(1);
          end
        end
        OP_NOISE: noise_r <= noise_acc[LVL_W-1:0];
        OP_LIM_LOAD_RR: begin
          base_r    <= rr_r;
          lcnt_r    <= LIM_LOW;
          started_r <= 1'b1;
        end
        OP_LIM_STEP: begin
          lim_r[lcnt_r] <= lim_val;
          lcnt_r        <= lcnt_r + 2'd1;
        end
        OP_DECIDE: begin
          k_r      <= PEAK_AW'(1);
          j_r      <= '0;
          sum_r    <= '0;
          cnt_r    <= '0;
          sel_ok_r <= 1'b1;
          if (miss_hit) begin
            miss_r <= miss_inc;
            warn_r <= (miss_inc == miss_limit_r);
          end
          if (stat.accept) begin
            last_r       <= idx_r;
            sig_r        <= sig_acc[LVL_W-1:0];
            ok_ring_r[0]  <= rr_r;
            all_ring_r[0] <= rr_r;
            for (int i = 1; i < RR_DEPTH; i++) begin
              ok_ring_r[i]  <= ok_ring_r[i-1];
              all_ring_r[i] <= all_ring_r[i-1];
            end
            miss_r      <= '0;
            res_valid_r <= 1'b1;
            res_val_r   <= cand_r;
            res_idx_r   <= idx_r;
            res_rr_r    <= rr_r;
          end
        end
        OP_SB_CHECK: k_r <= k_r + PEAK_AW'(1);
        OP_SB_HIT: begin
          last_r        <= sb_idx;
          sig_r         <= sig_sb[LVL_W-1:0];
          all_ring_r[0] <= rr_sb;
          for (int i = 1; i < RR_DEPTH; i++) all_ring_r[i] <= all_ring_r[i-1];
          sel_ok_r    <= 1'b0;
          res_valid_r <= 1'b1;
          res_sb_r    <= 1'b1;
          res_val_r   <= sb_val;
          res_idx_r   <= sb_idx;
          res_rr_r    <= rr_sb;
        end
        OP_MEAN_STEP: begin
          sum_r <= sum_add;
          cnt_r <= cnt_add;
          j_r   <= j_r + RR_IW'(1);
          if (stat.mean_last) begin
            q_r    <= sum_add;
            rem_r  <= '0;
            dcnt_r <= '0;
          end
        end
        OP_DIV_STEP: begin
          q_r    <= q_nxt;
          rem_r  <= rem_nxt;
          dcnt_r <= dcnt_r + DIV_CW'(1);
          if (stat.div_last) begin
            base_r <= (cnt_r == '0) ? '0 : q_nxt[RR_W-1:0];
            lcnt_r <= LIM_LOW;
          end
        end
        OP_THR: begin
          thr1_r <= thr_sum[LVL_FRAC+2 +: SAMPLE_WIDTH];
          thr2_r <= {1'b0, thr_sum[LVL_FRAC+3 +: SAMPLE_WIDTH-1]};
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      out_user_r <= res_valid_r;
      out_data_r <= OUT_DATA_W'({warn_r,
                                 res_valid_r && (res_val_r < low_level_r),
                                 res_sb_r, res_rr_r, res_idx_r, res_val_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> verif/tb_top.sv
// tb_top: self-checking testbench for the qrs_peak_detector QRS peak detector.
// Depends on rtl/qrs_pkg.sv and the detector RTL; drives synthetic ECG rhythms and
// checks every result against a cycle-free prediction of the detection algorithm.
`timescale 1ns / 1ps

module tb_top;
  import qrs_pkg::*;

  // One expected or observed result transaction
  typedef struct packed {
    logic        valid;
    logic [15:0] value;
    logic [31:0] index;
    logic [15:0] rr;
    logic        sb;
    logic        low;
    logic        miss;
  } beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_AW-1:0]     cfg_addr = CFG_LOW_LEVEL;
  logic [CFG_DW-1:0]     cfg_wdata = '0;

  qrs_peak_detector i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial forever #4 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Detector prediction state
  // ---------------------------------------------------------------------------
  logic [15:0]         hist0, hist1;        // newest and older previous sample
  logic [31:0]         n_samples;
  logic [31:0][15:0]   pk_val;              // [0] youngest peak
  logic [31:0][31:0]   pk_idx;
  logic [31:0]         last_beat_idx;
  logic [7:0][15:0]    rr_all, rr_ok;       // [0] newest interval, 0 = empty slot
  logic [18:0]         sig_lvl, noise_lvl;  // 16.3 fixed point
  logic [15:0]         thr1, thr2;
  logic [15:0]         lim_lo, lim_hi, lim_miss;
  logic                locked;
  logic [3:0]          miss_run;
  logic [15:0]         low_level;
  logic [3:0]          miss_limit;

  beat_t beats_due[$];   // predicted results in arrival order
  int    mismatches = 0;
  int    send_gap_pct = 0;
  int    recv_idle_pct = 0;

  function automatic logic [15:0] clip_rr(input logic [31:0] d);
    return (d > 32'd65535) ? 16'hFFFF : d[15:0];
  endfunction

  function automatic logic [15:0] mean_rr(input logic [7:0][15:0] r);
    int unsigned sum, cnt;
    sum = 0;
    cnt = 0;
    for (int k = 0; k < 8; k++) begin
      if (r[k] != 16'd0) begin
        sum += r[k];
        cnt++;
      end
    end
    return (cnt != 0) ? 16'(sum / cnt) : 16'd0;
  endfunction

  task automatic update_limits(input logic [15:0] base);
    lim_lo   = clip_rr((32'(base) * 942) >> 10);
    lim_hi   = clip_rr((32'(base) * 1188) >> 10);
    lim_miss = clip_rr((32'(base) * 1700) >> 10);
  endtask

  task automatic update_thresholds();
    int unsigned t;
    t = (3 * int'(noise_lvl) + int'(sig_lvl)) >> 5;
    thr1 = 16'(t);
    thr2 = 16'(t) >> 1;
  endtask

  task automatic clear_model();
    hist0 = '0; hist1 = '0; n_samples = '0;
    pk_val = '0; pk_idx = '0; last_beat_idx = '0;
    rr_all = '0; rr_ok = '0; sig_lvl = '0; noise_lvl = '0;
    thr1 = '0; thr2 = '0; lim_lo = '0; lim_hi = '0; lim_miss = '0;
    locked = 1'b0; miss_run = '0;
    low_level = LOW_LEVEL_RST;
    miss_limit = MISS_LIMIT_RST;
  endtask

  // Advance the detector by one sample and queue the result it causes, if any
  task automatic detect_beat(input logic [15:0] s);
    logic [15:0] cand, rr, rr2;
    logic [31:0] idx;
    logic        warn, found;
    beat_t       res;
    cand = hist0;
    idx = n_samples;
    warn = 1'b0;
    found = 1'b0;
    res = '0;
    if (hist1 < cand && cand > s) begin
      pk_val = {pk_val[30:0], cand};
      pk_idx = {pk_idx[30:0], idx};
      if (cand > thr1) begin
        rr = (idx >= last_beat_idx) ? clip_rr(idx - last_beat_idx) : 16'd0;
        if (!locked) begin
          update_limits(rr);
          locked = 1'b1;
        end
        if ((rr < lim_lo || rr > lim_hi) && miss_run != MISS_MAX) begin
          miss_run++;
          if (miss_run == miss_limit) warn = 1'b1;
        end
        if (rr > lim_lo && rr < lim_hi) begin
          // regular beat
          last_beat_idx = idx;
          sig_lvl = 19'((32'(cand) * 8 + 7 * 32'(sig_lvl)) >> 3);
          rr_ok = {rr_ok[6:0], rr};
          rr_all = {rr_all[6:0], rr};
          update_limits(mean_rr(rr_ok));
          update_thresholds();
          miss_run = '0;
          res.valid = 1'b1; res.value = cand; res.index = idx; res.rr = rr;
        end else if (rr > lim_miss) begin
          // searchback: youngest older peak above the second threshold and after the last beat
          for (int k = 1; k < 32; k++) begin
            if (!found && pk_val[k] > thr2 && pk_idx[k] > last_beat_idx) begin
              found = 1'b1;
              rr2 = clip_rr(pk_idx[k] - last_beat_idx);
              last_beat_idx = pk_idx[k];
              rr_all = {rr_all[6:0], rr2};
              sig_lvl = 19'((32'(pk_val[k]) * 8 + 3 * 32'(sig_lvl)) >> 2);
              update_limits(mean_rr(rr_all));
              update_thresholds();
              res.valid = 1'b1; res.sb = 1'b1;
              res.value = pk_val[k]; res.index = pk_idx[k]; res.rr = rr2;
            end
          end
        end
      end else begin
        noise_lvl = 19'((32'(cand) * 8 + 7 * 32'(noise_lvl)) >> 3);
        update_thresholds();
      end
    end
    hist1 = cand;
    hist0 = s;
    if (n_samples != 32'hFFFF_FFFF) n_samples++;
    if (res.valid || warn) begin
      res.low = res.valid && (res.value < low_level);
      res.miss = warn;
      beats_due.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check results first, then predict from the accepted sample
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    beat_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[15:0], out_tdata[47:16], out_tdata[63:48],
             out_tdata[64], out_tdata[65], out_tdata[66]};
      if (beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tuser=%0b tdata=%h", out_tuser, out_tdata);
      end else begin
        want = beats_due.pop_front();
        if (got.valid != want.valid || got.value != want.value || got.index != want.index ||
            got.rr != want.rr || got.sb != want.sb || got.low != want.low ||
            got.miss != want.miss || out_tdata[OUT_DATA_W-1:67] != '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp v=%0b val=%0d idx=%0d rr=%0d sb=%0b low=%0b miss=%0b | %s",
                     want.valid, want.value, want.index, want.rr, want.sb, want.low,
                     want.miss, $sformatf("got v=%0b val=%0d idx=%0d rr=%0d sb=%0b low=%0b miss=%0b",
                     got.valid, got.value, got.index, got.rr, got.sb, got.low, got.miss));
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) detect_beat(in_tdata);
  end

  // Receiver back-pressure
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic [15:0] s);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold off until every predicted result has drained, then let the block settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
    repeat (128) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_LOW_LEVEL) low_level = data;
    else miss_limit = data[3:0];
    @(posedge clk);
  endtask

  // Synthetic rhythm: triangular beats over low noise, with weak beats that only a
  // searchback can find, dropped beats and premature beats mixed in.
  task automatic run_rhythm(input int n, input int pmin, input int pmax, input int amax);
    int sent, p, len, amp, top, noise, kind;
    sent = 0;
    p = $urandom_range(pmin, pmax);
    while (sent < n) begin
      amp = $urandom_range(amax / 4, amax);
      noise = amp / 40;
      kind = $urandom_range(99);
      top = (kind < 12) ? amp / 5 : (kind < 18) ? noise : amp;
      len = p + $urandom_range(0, 2) - 1;
      if (kind >= 18 && kind < 23) len = p / 2;
      send_sample(16'(top / 4));
      send_sample(16'(top / 2));
      send_sample(16'(top));
      send_sample(16'(top / 2));
      send_sample(16'(top / 4));
      for (int k = 5; k < len; k++) send_sample(16'($urandom_range(0, noise)));
      sent += len;
      if ($urandom_range(49) == 0) p = $urandom_range(pmin, pmax);  // rate change
    end
  endtask

  task automatic run_noise(input int n);
    for (int k = 0; k < n; k++) send_sample(16'($urandom_range(0, 65535)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Field extremes, plateaus (no strict maximum), the very first candidate and
  // a short clean rhythm under reset register values.
  task automatic test_directed();
    logic [15:0] seq [$];
    send_gap_pct = 15;
    recv_idle_pct = 83;
    seq = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd1,
            16'h5555, 16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF, 16'd0};
    foreach (seq[k]) send_sample(seq[k]);
    run_rhythm(10, 10, 10, 1000);
    wait_idle();
  endtask

  // Register extremes: no low warning and warning on the first miss
  task automatic test_cfg_extremes();
    write_reg(CFG_LOW_LEVEL, 16'd0);
    write_reg(CFG_MISS_LIMIT, 16'd1);
    send_gap_pct = 15;
    recv_idle_pct = 83;
    run_rhythm(300, 10, 24, 65535);
    run_noise(50);
    wait_idle();
  endtask

  // Low warning below 0xFFFF, miss warning never (limit zero) then at the top limit;
  // the sender pauses until the block has drained midway
  task automatic test_searchback();
    write_reg(CFG_LOW_LEVEL, 16'hFFFF);
    write_reg(CFG_MISS_LIMIT, 16'd0);
    send_gap_pct = 83;
    recv_idle_pct = 15;
    run_rhythm(150, 8, 16, 65535);
    wait_idle();
    write_reg(CFG_MISS_LIMIT, 16'd15);
    run_noise(50);
    run_rhythm(150, 12, 30, 65535);
    wait_idle();
  endtask

  // Small amplitudes around the low value level, full rate on both sides
  task automatic test_low_amplitude();
    write_reg(CFG_LOW_LEVEL, 16'd2000);
    write_reg(CFG_MISS_LIMIT, 16'd3);
    send_gap_pct = 0;
    recv_idle_pct = 0;
    run_rhythm(300, 10, 20, 4000);
    run_noise(50);
    wait_idle();
  endtask

  initial begin
    clear_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_cfg_extremes();
    test_searchback();
    test_low_amplitude();
    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
